// ===== hw/rtl/ogru_pkg.sv =====
// shared types and constants for the occupancy grid ray update unit
// no dependencies

package ogru_pkg;

    // default grid geometry and cell value width
    localparam int GRID_CELLS_DEF    = 256;
    localparam int LOG_ODDS_BITS_DEF = 16;

    // cell coordinate width once the centre offset is added
    localparam int CRD_W  = 17;
    // bresenham error register width
    localparam int ERR_W  = 19;
    // step and threshold register widths
    localparam int STEP_W = 13;
    localparam int THR_W  = 16;
    // result field widths
    localparam int LO_OUT_W = 16;
    localparam int FREED_W  = 12;

    // apb register map, index = paddr[3:2]
    localparam int PADDR_W = 4;
    typedef enum logic [1:0] {
        REG_FREE_STEP = 2'd0,
        REG_OCC_STEP  = 2'd1,
        REG_OCC_THR   = 2'd2,
        REG_SPARE     = 2'd3
    } t_reg_idx;

    // input function select
    localparam logic FUNC_RAY   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR   = 3'd0,
        ST_IDLE    = 3'd1,
        ST_OCC_RD  = 3'd2,
        ST_OCC_WR  = 3'd3,
        ST_WALK_RD = 3'd4,
        ST_WALK_WR = 3'd5,
        ST_TGT_RD  = 3'd6,
        ST_DONE    = 3'd7
    } t_state;

endpackage

// ===== hw/rtl/occupancy_grid_raycast_update_unit.sv =====
// occupancy grid with log-odds cells, bresenham ray updates and cell queries
// one cell memory, read and written in separate steps by a small sequencer; depends on ogru_pkg
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------------
//  s_axis    | in        | tvalid / tready              | tdata: rx, ry, tx, ty; tuser: func
//  m_axis    | out       | tvalid / tready              | tdata: result fields
//  apb       | in        | psel, penable, pwrite, pready| free/occupied step, threshold
//
// a query reads the target cell; a ray reads and writes the hit cell when it lies on the
// grid, then spends a read step and a write step on every cell of the line, then reads the hit cell
// after reset a clearing pass writes every cell unknown, during which no request is taken
// (register writes are)
// the next request is taken while a finished result still waits on m_axis; the block
// only holds in its last step if the previous result has not yet been taken

module occupancy_grid_raycast_update_unit
    import ogru_pkg::*;
#(
    parameter int GRID_CELLS    = GRID_CELLS_DEF,
    parameter int LOG_ODDS_BITS = LOG_ODDS_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input requests
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // [15:0] robot_x, [31:16] robot_y, [47:32] target_x, [63:48] target_y
    input  logic [63:0]        i_s_axis_tdata,
    // [0] func
    input  logic [0:0]         i_s_axis_tuser,
    // results
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [0] target_in_bounds, [1] cell_known, [2] cell_occupied,
    // [18:3] cell_log_odds, [30:19] cells_freed, [31] zero
    output logic [31:0]        o_m_axis_tdata,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int L      = LOG_ODDS_BITS;
    localparam int DEPTH  = GRID_CELLS * GRID_CELLS;
    localparam int MW     = $clog2(DEPTH);
    localparam int AW     = $clog2(GRID_CELLS);
    localparam int WORD_W = L + 1;
    localparam int SW     = ((L > STEP_W + 1) ? L : STEP_W + 1) + 1;
    localparam int TW     = ((L > THR_W) ? L : THR_W) + 1;
    localparam int DW     = 16;

    localparam logic signed [CRD_W-1:0] GRID_S = CRD_W'(GRID_CELLS);
    localparam logic signed [CRD_W-1:0] HALF_S = CRD_W'(GRID_CELLS / 2);
    localparam logic [MW-1:0]           LAST_ADDR = MW'(DEPTH - 1);
    localparam logic [FREED_W-1:0]      FREED_MAX = '1;

    // ---------------------------------------------------------------- registers
    t_state                     r_state, n_state;
    logic signed [CRD_W-1:0]    r_rx, r_ry, r_tx, r_ty;
    logic signed [CRD_W-1:0]    r_wx, r_wy, n_wx, n_wy;
    logic signed [ERR_W-1:0]    r_err, n_err;
    logic [FREED_W-1:0]         r_freed, n_freed;
    logic                       r_cur_inb, n_cur_inb;
    logic [MW-1:0]              r_clr_addr;
    logic [WORD_W-1:0]          r_rd_data;
    logic                       r_out_valid;
    logic [31:0]                r_out_data, n_out_data;
    logic signed [STEP_W-1:0]   r_free_step;
    logic [STEP_W-1:0]          r_occ_step;
    logic signed [THR_W-1:0]    r_occ_thr;

    logic [WORD_W-1:0]          mem [DEPTH];

    // ---------------------------------------------------------------- handshakes
    logic s_acc;
    logic out_free;
    logic cfg_wr;
    t_reg_idx cfg_idx;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign pready          = 1'b1;
    assign cfg_wr          = psel && penable && pwrite && pready;
    assign cfg_idx         = t_reg_idx'(paddr[3:2]);

    // ---------------------------------------------------------------- geometry
    logic signed [CRD_W:0]   dx_s, dy_s;
    logic [DW-1:0]           dx, dy;
    logic                    stx_pos, sty_pos;
    logic                    tgt_inb, walk_inb, walk_done;
    logic [MW-1:0]           tgt_addr, walk_addr;

    assign dx_s    = (CRD_W+1)'(r_tx) - (CRD_W+1)'(r_rx);
    assign dy_s    = (CRD_W+1)'(r_ty) - (CRD_W+1)'(r_ry);
    assign dx      = dx_s[CRD_W] ? DW'(-dx_s) : DW'(dx_s);
    assign dy      = dy_s[CRD_W] ? DW'(-dy_s) : DW'(dy_s);
    assign stx_pos = r_rx < r_tx;
    assign sty_pos = r_ry < r_ty;

    assign tgt_inb  = (r_tx >= 0) && (r_tx < GRID_S) && (r_ty >= 0) && (r_ty < GRID_S);
    assign walk_inb = (r_wx >= 0) && (r_wx < GRID_S) && (r_wy >= 0) && (r_wy < GRID_S);
    assign tgt_addr  = MW'(r_ty[AW-1:0]) * MW'(GRID_CELLS) + MW'(r_tx[AW-1:0]);
    assign walk_addr = MW'(r_wy[AW-1:0]) * MW'(GRID_CELLS) + MW'(r_wx[AW-1:0]);

    // at or past the target on both axes, in the direction of travel
    assign walk_done = (stx_pos ? (r_wx >= r_tx) : (r_wx <= r_tx)) &&
                       (sty_pos ? (r_wy >= r_ty) : (r_wy <= r_ty));

    // bresenham step
    logic signed [ERR_W:0] e2, dx_e, dy_e, err_sum;
    logic                  step_x, step_y;

    assign e2      = {r_err, 1'b0};
    assign dx_e    = (ERR_W+1)'(dx);
    assign dy_e    = (ERR_W+1)'(dy);
    assign step_x  = e2 > -dy_e;
    assign step_y  = e2 < dx_e;
    assign err_sum = (ERR_W+1)'(r_err) - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);

    // ---------------------------------------------------------------- shared saturating adder
    logic signed [L-1:0]  old_val, sat_val;
    logic signed [SW-1:0] step_ext, sum;
    logic                 sum_ovf;

    assign old_val  = r_rd_data[L] ? $signed(r_rd_data[L-1:0]) : '0;
    assign step_ext = (r_state == ST_OCC_WR) ? $signed(SW'(r_occ_step)) : SW'(r_free_step);
    assign sum      = SW'(old_val) + step_ext;
    assign sum_ovf  = !((&sum[SW-1:L-1]) || !(|sum[SW-1:L-1]));
    assign sat_val  = sum_ovf ? (sum[SW-1] ? {1'b1, {(L-1){1'b0}}} : {1'b0, {(L-1){1'b1}}})
                              : sum[L-1:0];

    // ---------------------------------------------------------------- result forming
    logic                    res_known, res_occ, res_ovf;
    logic signed [L-1:0]     res_val;
    logic signed [TW-1:0]    res_ext;
    logic [LO_OUT_W-1:0]     res_lo;

    assign res_known = tgt_inb && r_rd_data[L];
    assign res_val   = res_known ? $signed(r_rd_data[L-1:0]) : '0;
    assign res_ext   = TW'(res_val);
    assign res_occ   = res_known && (res_ext > TW'(r_occ_thr));
    assign res_ovf   = !((&res_ext[TW-1:LO_OUT_W-1]) || !(|res_ext[TW-1:LO_OUT_W-1]));
    assign res_lo    = res_ovf ? (res_ext[TW-1] ? {1'b1, {(LO_OUT_W-1){1'b0}}}
                                                : {1'b0, {(LO_OUT_W-1){1'b1}}})
                               : res_ext[LO_OUT_W-1:0];

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) n_state = (i_s_axis_tuser[0] == FUNC_QUERY) ? ST_TGT_RD : ST_OCC_RD;
            end
            ST_OCC_RD:  n_state = tgt_inb ? ST_OCC_WR : ST_WALK_RD;
            ST_OCC_WR:  n_state = ST_WALK_RD;
            ST_WALK_RD: n_state = ST_WALK_WR;
            ST_WALK_WR: n_state = walk_done ? ST_TGT_RD : ST_WALK_RD;
            ST_TGT_RD:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- sequencer outputs
    logic              mem_rd_en, mem_wr_en;
    logic [MW-1:0]     mem_rd_addr, mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = tgt_addr;
        mem_wr_en   = 1'b0;
        mem_wr_addr = tgt_addr;
        mem_wr_data = {1'b1, sat_val};
        n_wx        = r_wx;
        n_wy        = r_wy;
        n_err       = r_err;
        n_freed     = r_freed;
        n_cur_inb   = r_cur_inb;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_addr;
                mem_wr_data = '0;
            end
            ST_IDLE: begin
                n_freed = '0;
            end
            ST_OCC_RD: begin
                mem_rd_en = tgt_inb;
                n_wx      = r_rx;
                n_wy      = r_ry;
                n_err     = ERR_W'(dx_e - dy_e);
            end
            ST_OCC_WR: begin
                mem_wr_en = 1'b1;
            end
            ST_WALK_RD: begin
                mem_rd_en   = walk_inb;
                mem_rd_addr = walk_addr;
                n_cur_inb   = walk_inb;
            end
            ST_WALK_WR: begin
                mem_wr_en   = r_cur_inb;
                mem_wr_addr = walk_addr;
                if (r_cur_inb && r_freed != FREED_MAX) n_freed = r_freed + 1'b1;
                if (!walk_done) begin
                    n_err = ERR_W'(err_sum);
                    if (step_x) n_wx = stx_pos ? r_wx + 1'b1 : r_wx - 1'b1;
                    if (step_y) n_wy = sty_pos ? r_wy + 1'b1 : r_wy - 1'b1;
                end
            end
            ST_TGT_RD: begin
                mem_rd_en = tgt_inb;
            end
            ST_DONE: begin
                // a waiting result keeps its data until taken
                if (out_free) begin
                    n_out_data = {1'b0, r_freed, res_lo, res_occ, res_known, tgt_inb};
                end
            end
            default: begin
                n_freed = r_freed;
            end
        endcase
    end

    // ---------------------------------------------------------------- cell memory
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) mem[mem_wr_addr] <= mem_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd_en) r_rd_data <= mem[mem_rd_addr];
    end

    // ---------------------------------------------------------------- control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_rx <= CRD_W'($signed(i_s_axis_tdata[15:0])) + HALF_S;
            r_ry <= CRD_W'($signed(i_s_axis_tdata[31:16])) + HALF_S;
            r_tx <= CRD_W'($signed(i_s_axis_tdata[47:32])) + HALF_S;
            r_ty <= CRD_W'($signed(i_s_axis_tdata[63:48])) + HALF_S;
        end
        r_wx       <= n_wx;
        r_wy       <= n_wy;
        r_err      <= n_err;
        r_freed    <= n_freed;
        r_cur_inb  <= n_cur_inb;
        r_out_data <= n_out_data;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_step <= -STEP_W'(104);
            r_occ_step  <= STEP_W'(217);
            r_occ_thr   <= THR_W'(281);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FREE_STEP: r_free_step <= pwdata[STEP_W-1:0];
                REG_OCC_STEP:  r_occ_step  <= pwdata[STEP_W-1:0];
                REG_OCC_THR:   r_occ_thr   <= pwdata[THR_W-1:0];
                default:       r_occ_thr   <= r_occ_thr;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FREE_STEP: prdata = 32'(r_free_step);
            REG_OCC_STEP:  prdata = 32'(r_occ_step);
            REG_OCC_THR:   prdata = 32'(r_occ_thr);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- assertions
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_s_axis_tready)
        else $error("request taken during clearing pass");

    a_freed_only_inb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK_WR && !r_cur_inb) |=> $stable(r_freed))
        else $error("freed count moved for an out-of-bounds cell");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside the final step");

    a_occ_write_inb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OCC_WR) |-> tgt_inb)
        else $error("occupied update on a cell outside the grid");

endmodule
